// File: design/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared constants and types for the indexed max-heap.
// ----------------------------------------------------------------------------
package imh_pkg;
  localparam int VALUE_BITS = 16;
  localparam int LABEL_BITS = 8;
  localparam int SLOT_BITS  = 8;
  localparam int COUNT_BITS = 9;
  localparam logic [COUNT_BITS-1:0] CAPACITY = 9'd256;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [LABEL_BITS-1:0] label;
  } entry_t;

  // heap memory port bundle
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    entry_t               wr_data;
    logic [SLOT_BITS-1:0] rd_addr;
  } heap_req_t;
endpackage

// File: design/indexed_max_heap_core.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_core
// Indexed binary max-heap with insert, remove-by-label and query.
// ----------------------------------------------------------------------------
// One item is worked at a time. A query or a rejected action goes straight
// to the result. Insert writes the new entry into the next free slot and
// climbs it a level per swap. Remove moves the last entry into the freed
// slot, then climbs or sinks it a level per swap. All accesses go through
// the one-read, one-write entry memory (read, compare, swap writes). The
// root is held in a register so max_value needs no memory read. The label
// index and presence bits live beside the heap. While a result waits on
// out_stall the next item is worked and held at its end.
module indexed_max_heap_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [imh_pkg::VALUE_BITS-1:0] value,
  input  logic [imh_pkg::LABEL_BITS-1:0] label,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imh_pkg::VALUE_BITS-1:0] removed_value,
  output logic [imh_pkg::VALUE_BITS-1:0] max_value,
  output logic                          empty_res,
  output logic [1:0]                    status
);
  import imh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RDSLOT = 4'd1, S_RDPOS = 4'd2,
                         S_RDLAST = 4'd3, S_PLACE = 4'd4, S_UPRD = 4'd5,
                         S_UPCMP = 4'd6, S_DNL = 4'd7, S_DNR = 4'd8,
                         S_DNCMP = 4'd9, S_SWAP = 4'd10, S_DONE = 4'd11,
                         S_RDPAR = 4'd12, S_GETLAST = 4'd13;

  logic [3:0] state;
  logic [COUNT_BITS-1:0] count;
  logic [255:0] present;
  logic [SLOT_BITS-1:0] slot_mem [0:255];
  logic [SLOT_BITS-1:0] slot_rd;
  logic slot_we;
  logic [LABEL_BITS-1:0] slot_wa;
  logic [SLOT_BITS-1:0] slot_wd;

  heap_req_t hreq;
  entry_t hrd;
  imh_heap_ram u_ram (.clk(clk), .req(hreq), .rd_data(hrd));

  entry_t cur, other, lft, root;
  logic [SLOT_BITS-1:0] pos, opos;
  logic up_mode;
  logic [LABEL_BITS-1:0] lab;
  logic [1:0] act;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] rem_r;
  logic [1:0] st_r;

  logic [COUNT_BITS-1:0] pos_w, lidx, ridx;
  assign pos_w = {1'b0, pos};
  assign lidx  = {pos, 1'b1};
  assign ridx  = lidx + 9'd1;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[lab];
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    hreq = '0;
    slot_we = 1'b0;
    slot_wa = cur.label;
    slot_wd = pos;
    case (state)
      S_RDPOS:  hreq.rd_addr = slot_rd;
      S_RDLAST: hreq.rd_addr = count[SLOT_BITS-1:0];
      S_PLACE: begin
        hreq.wr_en = 1'b1; hreq.wr_addr = pos; hreq.wr_data = cur;
        slot_we = 1'b1;
        hreq.rd_addr = (pos - 8'd1) >> 1;
      end
      S_UPRD: hreq.rd_addr = (pos - 8'd1) >> 1;
      S_DNL:  hreq.rd_addr = lidx[SLOT_BITS-1:0];
      S_DNR:  hreq.rd_addr = ridx[SLOT_BITS-1:0];
      S_SWAP: begin
        // other moves to pos, cur moves to opos
        hreq.wr_en = 1'b1; hreq.wr_addr = pos; hreq.wr_data = other;
        slot_we = 1'b1; slot_wa = other.label; slot_wd = pos;
      end
      S_RDPAR: begin
        hreq.wr_en = 1'b1; hreq.wr_addr = opos; hreq.wr_data = cur;
        slot_we = 1'b1; slot_wa = cur.label; slot_wd = opos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      present <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act <= action; val <= value; lab <= label;
            rem_r <= '0; st_r <= ST_OK;
            state <= S_RDSLOT;
          end
        end
        S_RDSLOT: begin
          if (act == ACT_INSERT && !present[lab] && count < CAPACITY) begin
            present[lab] <= 1'b1;
            cur <= '{value: val, label: lab};
            pos <= count[SLOT_BITS-1:0];
            count <= count + 9'd1;
            up_mode <= 1'b1;
            state <= S_PLACE;
          end else if (act == ACT_REMOVE && present[lab] && count != '0) begin
            state <= S_RDPOS;
          end else begin
            state <= S_DONE;
            if (act == ACT_INSERT) st_r <= present[lab] ? ST_DUP : ST_FULL;
            else if (act == ACT_REMOVE) st_r <= ST_ABSENT;
          end
        end
        S_RDPOS: begin
          pos <= ({1'b0, slot_rd} > count - 9'd1) ? count[SLOT_BITS-1:0] - 8'd1
                                                  : slot_rd;
          present[lab] <= 1'b0;
          count <= count - 9'd1;
          state <= S_RDLAST;
        end
        S_RDLAST: begin
          rem_r <= hrd.value;
          if (pos_w == count) state <= S_DONE;
          else state <= S_GETLAST;
        end
        S_GETLAST: begin
          cur <= hrd;
          up_mode <= 1'b0;
          state <= S_PLACE;
        end
        S_PLACE: state <= S_UPCMP;
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (pos != 8'd0 && cur.value > hrd.value) begin
            other <= hrd; opos <= (pos - 8'd1) >> 1;
            up_mode <= 1'b1;
            state <= S_SWAP;
          end else if (act == ACT_REMOVE && !up_mode) begin
            state <= (lidx < count) ? S_DNL : S_DONE;
          end else state <= S_DONE;
        end
        S_DNL: state <= S_DNR;
        S_DNR: begin
          lft <= hrd; state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (ridx < count && hrd.value > lft.value) begin
            if (hrd.value > cur.value) begin
              other <= hrd; opos <= ridx[SLOT_BITS-1:0]; state <= S_SWAP;
            end else state <= S_DONE;
          end else if (lft.value > cur.value) begin
            other <= lft; opos <= lidx[SLOT_BITS-1:0]; state <= S_SWAP;
          end else state <= S_DONE;
        end
        S_SWAP: state <= S_RDPAR;
        S_RDPAR: begin
          pos <= opos;
          if (up_mode) state <= (opos == 8'd0) ? S_DONE : S_UPRD;
          else state <= ({opos, 1'b1} >= count) ? S_DONE : S_DNL;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      removed_value <= rem_r;
      status <= st_r;
      empty_res <= (count == '0);
      max_value <= (count == '0) ? '0 : root.value;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // root shadow: track every write to slot 0
  always_ff @(posedge clk) begin
    if (hreq.wr_en && hreq.wr_addr == 8'd0) root <= hreq.wr_data;
  end
endmodule

// File: design/imh_heap_ram.sv
// ----------------------------------------------------------------------------
// imh_heap_ram
// Heap entry store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imh_heap_ram (
  input  logic               clk,
  input  imh_pkg::heap_req_t req,
  output imh_pkg::entry_t    rd_data
);
  import imh_pkg::*;

  entry_t mem [0:(1<<SLOT_BITS)-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end
endmodule
